/* src/sdfr_pkg.sv */
// sdfr_pkg: types, register map, status codes and field check functions
// for the serial display frame receiver; no dependencies
`timescale 1ns / 1ps

package sdfr_pkg;

  // receive buffer size, the frame length must stay below this minus three
  localparam int BUFFER_BYTES = 64;
  localparam int LEN_LIMIT    = BUFFER_BYTES - 3;

  localparam int ADDR_W = 5;

  typedef enum logic [2:0] {
    REG_HEADER_FIRST     = 3'd0,
    REG_HEADER_SECOND    = 3'd1,
    REG_GARBAGE_LIMIT    = 3'd2,
    REG_CHECK_MODE       = 3'd3,
    REG_EXPECTED_COMMAND = 3'd4,
    REG_EXPECTED_ADDRESS = 3'd5,
    REG_EXPECTED_COUNT   = 3'd6,
    REG_UNUSED           = 3'd7
  } reg_index_t;

  typedef enum logic [1:0] {
    MODE_NONE = 2'd0,
    MODE_REG  = 2'd1,
    MODE_RAM  = 2'd2,
    MODE_RSVD = 2'd3
  } check_mode_t;

  typedef enum logic [1:0] {
    PH_HUNT  = 2'd0,
    PH_HEAD2 = 2'd1,
    PH_LEN   = 2'd2,
    PH_BODY  = 2'd3
  } phase_t;

  typedef enum logic [2:0] {
    STAT_BODY       = 3'd0,
    STAT_OK         = 3'd1,
    STAT_NO_HEADER  = 3'd2,
    STAT_BAD_HEADER = 3'd3,
    STAT_TOO_LONG   = 3'd4,
    STAT_CMD        = 3'd5,
    STAT_ADDR       = 3'd6,
    STAT_CNT        = 3'd7
  } status_t;

  // mismatch flag bits
  localparam int MIS_CMD  = 0;
  localparam int MIS_ADDR = 1;
  localparam int MIS_CNT  = 2;

  typedef struct packed {
    logic [7:0]  header_first;
    logic [7:0]  header_second;
    logic [3:0]  garbage_limit;
    check_mode_t check_mode;
    logic [7:0]  expected_command;
    logic [15:0] expected_address;
    logic [7:0]  expected_count;
  } cfg_t;

  typedef struct packed {
    logic       has_data;
    logic [7:0] data_byte;
    logic [7:0] byte_index;
    logic       last;
    status_t    status;
  } result_t;

  // compare one body byte with the field expected at its position
  function automatic logic [2:0] check_byte(logic [7:0] idx, logic [7:0] b, cfg_t cfg);
    logic [2:0] f;
    f = 3'b000;
    case (cfg.check_mode)
      MODE_REG: begin
        if (idx == 8'd0 && b != cfg.expected_command) f[MIS_CMD] = 1'b1;
        if (idx == 8'd1 && b != cfg.expected_address[7:0]) f[MIS_ADDR] = 1'b1;
        if (idx == 8'd2 && b != cfg.expected_count) f[MIS_CNT] = 1'b1;
      end
      MODE_RAM: begin
        if (idx == 8'd0 && b != cfg.expected_command) f[MIS_CMD] = 1'b1;
        if (idx == 8'd1 && b != cfg.expected_address[15:8]) f[MIS_ADDR] = 1'b1;
        if (idx == 8'd2 && b != cfg.expected_address[7:0]) f[MIS_ADDR] = 1'b1;
        if (idx == 8'd3 && b != cfg.expected_count) f[MIS_CNT] = 1'b1;
      end
      default: f = 3'b000;
    endcase
    return f;
  endfunction

  // fields that a body of len bytes cannot hold
  function automatic logic [2:0] check_missing(logic [8:0] len, check_mode_t mode);
    logic [2:0] f;
    f = 3'b000;
    case (mode)
      MODE_REG: begin
        f[MIS_CMD]  = (len < 9'd1);
        f[MIS_ADDR] = (len < 9'd2);
        f[MIS_CNT]  = (len < 9'd3);
      end
      MODE_RAM: begin
        f[MIS_CMD]  = (len < 9'd1);
        f[MIS_ADDR] = (len < 9'd3);
        f[MIS_CNT]  = (len < 9'd4);
      end
      default: f = 3'b000;
    endcase
    return f;
  endfunction

  function automatic status_t final_status(logic [2:0] flags);
    status_t s;
    if (flags[MIS_CMD]) s = STAT_CMD;
    else if (flags[MIS_ADDR]) s = STAT_ADDR;
    else if (flags[MIS_CNT]) s = STAT_CNT;
    else s = STAT_OK;
    return s;
  endfunction

endpackage

/* src/sdfr_regs.sv */
// sdfr_regs: APB-style configuration registers of the frame receiver
// depends on sdfr_pkg
`timescale 1ns / 1ps

module sdfr_regs (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [sdfr_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  output sdfr_pkg::cfg_t            cfg
);

  sdfr_pkg::reg_index_t idx;
  logic                 wr_en;

  assign idx    = sdfr_pkg::reg_index_t'(paddr[4:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.header_first     <= 8'h5A;
      cfg.header_second    <= 8'hA5;
      cfg.garbage_limit    <= 4'd5;
      cfg.check_mode       <= sdfr_pkg::MODE_NONE;
      cfg.expected_command <= 8'h83;
      cfg.expected_address <= 16'h0000;
      cfg.expected_count   <= 8'h00;
    end else if (wr_en) begin
      case (idx)
        sdfr_pkg::REG_HEADER_FIRST:     cfg.header_first     <= pwdata[7:0];
        sdfr_pkg::REG_HEADER_SECOND:    cfg.header_second    <= pwdata[7:0];
        sdfr_pkg::REG_GARBAGE_LIMIT:    cfg.garbage_limit    <= pwdata[3:0];
        sdfr_pkg::REG_CHECK_MODE:
          cfg.check_mode <= sdfr_pkg::check_mode_t'(pwdata[1:0]);
        sdfr_pkg::REG_EXPECTED_COMMAND: cfg.expected_command <= pwdata[7:0];
        sdfr_pkg::REG_EXPECTED_ADDRESS: cfg.expected_address <= pwdata[15:0];
        sdfr_pkg::REG_EXPECTED_COUNT:   cfg.expected_count   <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      sdfr_pkg::REG_HEADER_FIRST:     prdata = {24'd0, cfg.header_first};
      sdfr_pkg::REG_HEADER_SECOND:    prdata = {24'd0, cfg.header_second};
      sdfr_pkg::REG_GARBAGE_LIMIT:    prdata = {28'd0, cfg.garbage_limit};
      sdfr_pkg::REG_CHECK_MODE:       prdata = {30'd0, cfg.check_mode};
      sdfr_pkg::REG_EXPECTED_COMMAND: prdata = {24'd0, cfg.expected_command};
      sdfr_pkg::REG_EXPECTED_ADDRESS: prdata = {16'd0, cfg.expected_address};
      sdfr_pkg::REG_EXPECTED_COUNT:   prdata = {24'd0, cfg.expected_count};
      default:                        prdata = 32'd0;
    endcase
  end

endmodule

/* src/sdfr_parse.sv */
// sdfr_parse: input register, frame state and per-byte parse logic
// depends on sdfr_pkg
`timescale 1ns / 1ps

module sdfr_parse (
  input  logic                clk,
  input  logic                rst,
  input  sdfr_pkg::cfg_t      cfg,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [7:0]          rx_byte,
  input  logic                res_ready,
  output logic                res_valid,
  output sdfr_pkg::result_t   res
);

  logic       in_full;
  logic [7:0] in_byte;
  logic       advance;
  logic       emit;

  sdfr_pkg::phase_t phase, phase_next;
  logic [3:0] garbage_count, garbage_count_next;
  logic [7:0] bytes_left, bytes_left_next;
  logic [7:0] body_index, body_index_next;
  logic [2:0] mismatch_flags, mismatch_flags_next;

  logic [3:0] gc_inc;
  logic [7:0] bl_dec;
  logic [2:0] flags;

  // the held byte is parsed once the result slot can take its outcome
  assign advance   = in_full && res_ready;
  assign in_stall  = in_full && !advance;
  assign res_valid = advance && emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_byte <= rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= sdfr_pkg::PH_HUNT;
      garbage_count  <= 4'd0;
      bytes_left     <= 8'd0;
      body_index     <= 8'd0;
      mismatch_flags <= 3'd0;
    end else if (advance) begin
      phase          <= phase_next;
      garbage_count  <= garbage_count_next;
      bytes_left     <= bytes_left_next;
      body_index     <= body_index_next;
      mismatch_flags <= mismatch_flags_next;
    end
  end

  always_comb begin
    phase_next          = phase;
    garbage_count_next  = garbage_count;
    bytes_left_next     = bytes_left;
    body_index_next     = body_index;
    mismatch_flags_next = mismatch_flags;
    emit                = 1'b0;
    res                 = '{has_data: 1'b0, data_byte: 8'd0, byte_index: 8'd0,
                            last: 1'b0, status: sdfr_pkg::STAT_BODY};
    gc_inc              = garbage_count + 4'd1;
    bl_dec              = bytes_left - 8'd1;
    flags               = mismatch_flags | sdfr_pkg::check_byte(body_index, in_byte, cfg);

    case (phase)
      sdfr_pkg::PH_HUNT: begin
        if (in_byte == cfg.header_first) begin
          garbage_count_next = 4'd0;
          phase_next         = sdfr_pkg::PH_HEAD2;
        end else if (gc_inc >= cfg.garbage_limit) begin
          // a limit of zero trips on the first garbage byte, like one
          garbage_count_next = 4'd0;
          emit               = 1'b1;
          res.last           = 1'b1;
          res.status         = sdfr_pkg::STAT_NO_HEADER;
        end else begin
          garbage_count_next = gc_inc;
        end
      end
      sdfr_pkg::PH_HEAD2: begin
        if (in_byte != cfg.header_second) begin
          phase_next = sdfr_pkg::PH_HUNT;
          emit       = 1'b1;
          res.last   = 1'b1;
          res.status = sdfr_pkg::STAT_BAD_HEADER;
        end else begin
          phase_next = sdfr_pkg::PH_LEN;
        end
      end
      sdfr_pkg::PH_LEN: begin
        if ({1'b0, in_byte} >= 9'(sdfr_pkg::LEN_LIMIT)) begin
          phase_next = sdfr_pkg::PH_HUNT;
          emit       = 1'b1;
          res.last   = 1'b1;
          res.status = sdfr_pkg::STAT_TOO_LONG;
        end else begin
          mismatch_flags_next = 3'd0;
          body_index_next     = 8'd0;
          if (in_byte == 8'd0) begin
            // empty body ends the frame with no data byte
            mismatch_flags_next = sdfr_pkg::check_missing(9'd0, cfg.check_mode);
            phase_next          = sdfr_pkg::PH_HUNT;
            emit                = 1'b1;
            res.last            = 1'b1;
            res.status          = sdfr_pkg::final_status(mismatch_flags_next);
          end else begin
            bytes_left_next = in_byte;
            phase_next      = sdfr_pkg::PH_BODY;
          end
        end
      end
      sdfr_pkg::PH_BODY: begin
        bytes_left_next = bl_dec;
        body_index_next = body_index + 8'd1;
        emit            = 1'b1;
        res.has_data    = 1'b1;
        res.data_byte   = in_byte;
        res.byte_index  = body_index;
        if (bl_dec == 8'd0) begin
          flags      = flags | sdfr_pkg::check_missing({1'b0, body_index} + 9'd1,
                                                       cfg.check_mode);
          phase_next = sdfr_pkg::PH_HUNT;
          res.last   = 1'b1;
          res.status = sdfr_pkg::final_status(flags);
        end
        mismatch_flags_next = flags;
      end
      default: phase_next = sdfr_pkg::PH_HUNT;
    endcase
  end

endmodule

/* src/sdfr_out.sv */
// sdfr_out: result register holding one result until the sink takes it
// depends on sdfr_pkg
`timescale 1ns / 1ps

module sdfr_out (
  input  logic              clk,
  input  logic              rst,
  input  logic              res_valid,
  input  sdfr_pkg::result_t res,
  output logic              res_ready,
  output logic              out_valid,
  input  logic              out_stall,
  output sdfr_pkg::result_t out_res
);

  logic out_full;

  assign out_valid = out_full;
  assign res_ready = !out_full || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_full <= 1'b0;
    end else if (res_valid) begin
      out_full <= 1'b1;
    end else if (!out_stall) begin
      out_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_res <= res;
    end
  end

endmodule

/* src/serial_display_frame_receiver_unit.sv */
// serial_display_frame_receiver_unit: top level of the serial frame receiver
// depends on sdfr_pkg, sdfr_regs, sdfr_parse, sdfr_out
`timescale 1ns / 1ps

// Takes one received byte per cycle while the input is not stalled and
// returns zero or one result per byte. A byte is registered on transfer,
// parsed against the frame state once the output register can take its
// result, and its result lands in the output register. Input stalls only
// when both the input register and the output register are full and the
// output is stalled. Configuration is to be written by the user through
// the APB-style port only while the block is idle; the block does not enforce it.

module serial_display_frame_receiver_unit (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [sdfr_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [7:0]                rx_byte,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic                      has_data,
  output logic [7:0]                data_byte,
  output logic [7:0]                byte_index,
  output logic                      last,
  output logic [2:0]                status
);

  sdfr_pkg::cfg_t    cfg;
  sdfr_pkg::result_t res;
  sdfr_pkg::result_t out_res;
  logic              res_valid;
  logic              res_ready;

  sdfr_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  sdfr_parse u_parse (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .rx_byte   (rx_byte),
    .res_ready (res_ready),
    .res_valid (res_valid),
    .res       (res)
  );

  sdfr_out u_out (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res       (res),
    .res_ready (res_ready),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign has_data   = out_res.has_data;
  assign data_byte  = out_res.data_byte;
  assign byte_index = out_res.byte_index;
  assign last       = out_res.last;
  assign status     = out_res.status;

endmodule

/* src/sdfr_checker.sv */
// sdfr_checker: port-level assertions on the frame receiver results
// depends on sdfr_pkg; bound to serial_display_frame_receiver_unit
`timescale 1ns / 1ps

module sdfr_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_stall,
  input logic       has_data,
  input logic [7:0] data_byte,
  input logic [7:0] byte_index,
  input logic       last,
  input logic [2:0] status
);

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(data_byte) && $stable(byte_index)
      && $stable(status) && $stable(last) && $stable(has_data))
    else $error("stalled result changed");

  // results without a body byte always close a frame or abort
  a_nodata_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !has_data |-> last && data_byte == 8'd0 && byte_index == 8'd0)
    else $error("non-data result not final or not zeroed");

  // a body-byte status only on a non-final data transfer
  a_body_status: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == sdfr_pkg::STAT_BODY |-> has_data && !last)
    else $error("body status on wrong result");

  // a final data byte reports accept or a field mismatch
  a_final_status: assert property (@(posedge clk) disable iff (rst)
    out_valid && has_data && last |->
      status == sdfr_pkg::STAT_OK || status == sdfr_pkg::STAT_CMD
      || status == sdfr_pkg::STAT_ADDR || status == sdfr_pkg::STAT_CNT)
    else $error("bad final status on data byte");

endmodule

bind serial_display_frame_receiver_unit sdfr_checker u_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .has_data   (has_data),
  .data_byte  (data_byte),
  .byte_index (byte_index),
  .last       (last),
  .status     (status)
);
